@@ src/nghri_pkg.sv @@
`default_nettype none
package nghri_pkg;

    localparam int MAX_NGRAM  = 4;
    localparam int MAX_HEADS  = 8;
    localparam int MAX_LAYERS = 2;

    localparam int HIST_DEPTH     = MAX_NGRAM - 1;
    localparam int COLS_PER_LAYER = (MAX_NGRAM - 1) * MAX_HEADS;
    localparam int MULT_DEPTH     = MAX_LAYERS * MAX_NGRAM;
    localparam int COL_DEPTH      = MAX_LAYERS * COLS_PER_LAYER;

    localparam int NG_W   = $clog2(MAX_NGRAM + 1);
    localparam int HD_W   = $clog2(MAX_HEADS + 1);
    localparam int LY_W   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LYC_W  = $clog2(MAX_LAYERS + 1);
    localparam int MA_W   = $clog2(MULT_DEPTH);
    localparam int CA_W   = $clog2(COL_DEPTH);
    localparam int CL_W   = $clog2(COLS_PER_LAYER);
    localparam int HC_W   = $clog2(HIST_DEPTH + 1);

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic [1:0] SEL_MULT  = 2'd0;
    localparam logic [1:0] SEL_PRIME = 2'd1;
    localparam logic [1:0] SEL_OFF   = 2'd2;

    localparam logic [1:0] CFG_NGRAM  = 2'd0;
    localparam logic [1:0] CFG_HEADS  = 2'd1;
    localparam logic [1:0] CFG_LAYERS = 2'd2;
    localparam logic [1:0] CFG_PAD    = 2'd3;

    // Remainder unit handshake
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

@@ src/nghri_mul.sv @@
`default_nettype none
// Shared 64x64 (low 64 bits) multiplier: one 16x64 partial product per cycle.
module nghri_mul
    import nghri_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      prod
);
    logic [63:0] acc_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] pp;

    // Partial product of the low digit of b
    assign pp = a_reg * {48'd0, b_reg[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the digit shift and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= 64'd0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp;
            a_reg   <= {a_reg[47:0], 16'd0};
            b_reg   <= {16'd0, b_reg[63:16]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

@@ src/nghri_rem.sv @@
`default_nettype none
// Restoring 64 by 32 remainder, one quotient bit per cycle.
module nghri_rem
    import nghri_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [63:0] num_reg;
    logic [32:0] part_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {part_reg[31:0], num_reg[63]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.dividend;
            part_reg <= 33'd0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[62:0], 1'b0};
            part_reg <= diff[32] ? shifted : diff;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = part_reg[31:0];
endmodule
`default_nettype wire

@@ src/ngram_hash_row_indexer.sv @@
`default_nettype none
// Channel  | Dir | Contents (lowest bit first)
// s_axis   | in  | tdata: table_select, table_layer, table_entry, table_value,
//          |     |        token_id, token_present, seq_start; tuser: req_type
// m_axis   | out | tdata: column_index, row_index; tuser: layer_index; tlast: last
// cfg      | in  | cfg_we, cfg_index, cfg_data
// A table write leaves the block ready for the next request. A token runs, per
// layer, one multiply per n-gram position in the shared multiplier and, per
// column, a table read, a start of the shared 64-step divider, a wait on it and
// the output; a zero prime skips the divider. Reset is asynchronous, sets the
// config registers to defaults and clears history and the output valid; tables
// are undefined until written. A stalled result holds the sequencer until it is taken.
module ngram_hash_row_indexer
    import nghri_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // select, layer, entry, value, id, present, start
    input  wire logic         s_axis_tuser,  // req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // column_index, row_index
    output logic              m_axis_tuser,  // layer_index
    output logic              m_axis_tlast
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_TOK, ST_MREAD, ST_MSTART, ST_MWAIT, ST_CREAD, ST_CDIV,
        ST_DWAIT, ST_EMIT, ST_OUT
    } state_t;

    // Config registers
    logic [2:0]  ngram_size_reg;
    logic [3:0]  head_count_reg;
    logic [1:0]  layer_count_reg;
    logic [23:0] pad_id_reg;

    // Tables
    logic [63:0] mult_mem [MULT_DEPTH];
    logic [31:0] prime_mem [COL_DEPTH];
    logic [31:0] off_mem [COL_DEPTH];
    logic [63:0] mult_rd_reg;
    logic [31:0] prime_rd_reg;
    logic [31:0] off_rd_reg;

    logic [23:0] hist_reg [HIST_DEPTH];
    logic [HC_W-1:0] hcnt_reg;

    state_t          state_reg;
    logic [23:0]     cur_reg;
    logic [NG_W-1:0] ng_reg;
    logic [HD_W-1:0] nh_reg;
    logic [LYC_W-1:0] nl_reg;
    logic [LY_W-1:0] lay_reg;
    logic [NG_W-1:0] s_reg;
    logic [HD_W-1:0] h_reg;
    logic [CL_W-1:0] col_reg;
    logic [63:0]     roll_reg;
    logic [31:0]     remv_reg;
    logic            is_last;

    // Output register
    logic        ovalid_reg;
    logic [4:0]  ocol_reg;
    logic [31:0] orow_reg;
    logic        olay_reg;
    logic        olast_reg;

    // Input fields
    logic [1:0]  in_sel;
    logic        in_layer;
    logic [4:0]  in_entry;
    logic [63:0] in_value;
    logic [23:0] in_id;
    logic        in_present;
    logic        in_start;
    assign in_sel     = s_axis_tdata[1:0];
    assign in_layer   = s_axis_tdata[2];
    assign in_entry   = s_axis_tdata[7:3];
    assign in_value   = s_axis_tdata[71:8];
    assign in_id      = s_axis_tdata[95:72];
    assign in_present = s_axis_tdata[96];
    assign in_start   = s_axis_tdata[97];

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Token for look-back s_reg
    logic [23:0] tok_s;
    always_comb
    begin
        tok_s = pad_id_reg;
        if (s_reg == '0)
            tok_s = cur_reg;
        else
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                if (s_reg == NG_W'(i + 1) && HC_W'(i + 1) <= hcnt_reg)
                    tok_s = hist_reg[i];
            end
        end
    end

    logic [MA_W-1:0] mult_addr;
    logic [CA_W-1:0] col_addr;
    assign mult_addr = MA_W'(lay_reg) * MA_W'(MAX_NGRAM) + MA_W'(s_reg);
    assign col_addr  = CA_W'(lay_reg) * CA_W'(COLS_PER_LAYER) + CA_W'(col_reg);

    // Shared units
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_prod;
    div_req_t    dreq;
    div_rsp_t    drsp;

    assign mul_start = (state_reg == ST_MSTART);
    nghri_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     ({40'd0, tok_s}),
        .b     (mult_rd_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign dreq.start    = (state_reg == ST_CDIV) && (prime_rd_reg != 32'd0);
    assign dreq.dividend = roll_reg;
    assign dreq.divisor  = prime_rd_reg;
    nghri_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign is_last = (LYC_W'(lay_reg) + LYC_W'(1) == nl_reg) && (s_reg + NG_W'(1) == ng_reg)
                     && (h_reg + HD_W'(1) == nh_reg);

    // Table writes and reads
    logic wr_ok_col;
    assign wr_ok_col = (in_layer < MAX_LAYERS) && (in_entry < COLS_PER_LAYER);
    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == REQ_WRITE && in_layer < MAX_LAYERS)
        begin
            if (in_sel == SEL_MULT && in_entry < MAX_NGRAM)
                mult_mem[MA_W'(in_layer) * MA_W'(MAX_NGRAM) + MA_W'(in_entry)] <= in_value;
            if (in_sel == SEL_PRIME && wr_ok_col)
                prime_mem[CA_W'(in_layer) * CA_W'(COLS_PER_LAYER) + CA_W'(in_entry)]
                    <= in_value[31:0];
            if (in_sel == SEL_OFF && wr_ok_col)
                off_mem[CA_W'(in_layer) * CA_W'(COLS_PER_LAYER) + CA_W'(in_entry)]
                    <= in_value[31:0];
        end
        mult_rd_reg  <= mult_mem[mult_addr];
        prime_rd_reg <= prime_mem[col_addr];
        off_rd_reg   <= off_mem[col_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ngram_size_reg  <= 3'd4;
            head_count_reg  <= 4'd8;
            layer_count_reg <= 2'd1;
            pad_id_reg      <= 24'd0;
            hcnt_reg        <= '0;
            ovalid_reg      <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= 24'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NGRAM:  ngram_size_reg  <= cfg_data[2:0];
                    CFG_HEADS:  head_count_reg  <= cfg_data[3:0];
                    CFG_LAYERS: layer_count_reg <= cfg_data[1:0];
                    CFG_PAD:    pad_id_reg      <= cfg_data;
                    default:    ;
                endcase
            end
            // Drop the taken result unless a new one replaces it this cycle
            if (ovalid_reg && m_axis_tready && state_reg != ST_EMIT)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && s_axis_tuser != REQ_WRITE)
                    begin
                        cur_reg <= in_present ? in_id : pad_id_reg;
                        if (in_start)
                            hcnt_reg <= '0;
                        ng_reg <= (ngram_size_reg < 3'd2) ? NG_W'(2) :
                                  (32'(ngram_size_reg) > MAX_NGRAM) ? NG_W'(MAX_NGRAM) :
                                  NG_W'(ngram_size_reg);
                        nh_reg <= (head_count_reg == 4'd0) ? HD_W'(1) :
                                  (32'(head_count_reg) > MAX_HEADS) ? HD_W'(MAX_HEADS) :
                                  HD_W'(head_count_reg);
                        nl_reg <= (layer_count_reg == 2'd0) ? LYC_W'(1) :
                                  (32'(layer_count_reg) > MAX_LAYERS) ? LYC_W'(MAX_LAYERS) :
                                  LYC_W'(layer_count_reg);
                        lay_reg   <= '0;
                        state_reg <= ST_TOK;
                    end
                end
                ST_TOK:
                begin
                    s_reg     <= '0;
                    col_reg   <= '0;
                    roll_reg  <= 64'd0;
                    state_reg <= ST_MREAD;
                end
                ST_MREAD:
                    state_reg <= ST_MSTART;
                ST_MSTART:
                    state_reg <= ST_MWAIT;
                ST_MWAIT:
                begin
                    if (mul_done)
                    begin
                        roll_reg <= roll_reg ^ mul_prod;
                        if (s_reg == '0)
                        begin
                            s_reg     <= NG_W'(1);
                            state_reg <= ST_MREAD;
                        end
                        else
                        begin
                            h_reg     <= '0;
                            state_reg <= ST_CREAD;
                        end
                    end
                end
                ST_CREAD:
                    state_reg <= ST_CDIV;
                ST_CDIV:
                begin
                    if (prime_rd_reg == 32'd0)
                    begin
                        remv_reg  <= roll_reg[31:0];
                        state_reg <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (drsp.done)
                    begin
                        remv_reg  <= drsp.rem;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        ovalid_reg <= 1'b1;
                        ocol_reg   <= 5'(col_reg);
                        orow_reg   <= remv_reg + off_rd_reg;
                        olay_reg   <= lay_reg[0];
                        olast_reg  <= is_last;
                        col_reg    <= col_reg + CL_W'(1);
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (h_reg + HD_W'(1) != nh_reg)
                    begin
                        h_reg     <= h_reg + HD_W'(1);
                        state_reg <= ST_CREAD;
                    end
                    else if (s_reg + NG_W'(1) != ng_reg)
                    begin
                        s_reg     <= s_reg + NG_W'(1);
                        state_reg <= ST_MREAD;
                    end
                    else if (LYC_W'(lay_reg) + LYC_W'(1) != nl_reg)
                    begin
                        lay_reg   <= lay_reg + LY_W'(1);
                        state_reg <= ST_TOK;
                    end
                    else
                    begin
                        for (int i = HIST_DEPTH - 1; i > 0; i--)
                            hist_reg[i] <= hist_reg[i - 1];
                        hist_reg[0] <= cur_reg;
                        if (hcnt_reg != HC_W'(HIST_DEPTH))
                            hcnt_reg <= hcnt_reg + HC_W'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'd0, orow_reg, ocol_reg};
    assign m_axis_tuser  = olay_reg;
    assign m_axis_tlast  = olast_reg;
endmodule
`default_nettype wire

@@ sim/tb_ngram_hash_row_indexer.sv @@
`timescale 1ns / 1ps

module tb_ngram_hash_row_indexer;
    import nghri_pkg::*;

    localparam logic REQ_HASH = 1'b1;

    // One expected row index, as it should leave the master side
    typedef struct {
        logic        lay;
        logic [4:0]  col;
        logic [31:0] row;
        logic        lst;
    } row_rec_t;

    // Scoreboard: private copy of tables, history and registers
    class row_index_board;
        logic [63:0] mult_tab [MULT_DEPTH];
        logic [31:0] prime_tab [COL_DEPTH];
        logic [31:0] off_tab [COL_DEPTH];
        logic [23:0] hist [HIST_DEPTH];
        int unsigned hist_n;
        int unsigned ngram_reg, heads_reg, layers_reg;
        logic [23:0] pad_reg;
        row_rec_t    rows_due[$];
        int          errors;
        int          tokens;
        int          writes;
        int          rows_seen;

        function new();
            foreach (mult_tab[i]) mult_tab[i] = '0;
            foreach (prime_tab[i]) prime_tab[i] = '0;
            foreach (off_tab[i]) off_tab[i] = '0;
            foreach (hist[i]) hist[i] = '0;
            hist_n = 0;
            ngram_reg = 4;
            heads_reg = 8;
            layers_reg = 1;
            pad_reg = '0;
            errors = 0;
            tokens = 0;
            writes = 0;
            rows_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] d);
            case (idx)
                CFG_NGRAM:  ngram_reg = d[2:0];
                CFG_HEADS:  heads_reg = d[3:0];
                CFG_LAYERS: layers_reg = d[1:0];
                CFG_PAD:    pad_reg = d;
                default: ;
            endcase
        endfunction

        // Apply one accepted request and queue the row indices it causes
        function void note_request(logic kind, logic [103:0] d);
            logic [1:0]  sel;
            logic        lay;
            logic [4:0]  ent;
            logic [63:0] val;
            logic [23:0] cur;
            logic [63:0] tok [MAX_NGRAM];
            logic [63:0] rolling;
            logic [63:0] rem;
            logic [31:0] p;
            int unsigned ng, nh, nl, total, cnt, col, base;
            row_rec_t    r;

            sel = d[1:0];
            lay = d[2];
            ent = d[7:3];
            val = d[71:8];
            if (kind == REQ_WRITE) begin
                writes++;
                case (sel)
                    SEL_MULT:  if (ent < MAX_NGRAM) mult_tab[lay*MAX_NGRAM + ent] = val;
                    SEL_PRIME: if (ent < COLS_PER_LAYER)
                                   prime_tab[lay*COLS_PER_LAYER + ent] = val[31:0];
                    SEL_OFF:   if (ent < COLS_PER_LAYER)
                                   off_tab[lay*COLS_PER_LAYER + ent] = val[31:0];
                    default: ;
                endcase
                return;
            end
            tokens++;
            ng = (ngram_reg < 2) ? 2 : (ngram_reg > MAX_NGRAM) ? MAX_NGRAM : ngram_reg;
            nh = (heads_reg < 1) ? 1 : (heads_reg > MAX_HEADS) ? MAX_HEADS : heads_reg;
            nl = (layers_reg < 1) ? 1 : (layers_reg > MAX_LAYERS) ? MAX_LAYERS : layers_reg;
            // sequence start drops all predecessors
            if (d[97]) hist_n = 0;
            cur = d[96] ? d[95:72] : pad_reg;
            tok[0] = {40'b0, cur};
            for (int s = 1; s < MAX_NGRAM; s++)
                tok[s] = {40'b0, (s <= hist_n) ? hist[s-1] : pad_reg};
            total = nl * (ng - 1) * nh;
            cnt = 0;
            for (int e = 0; e < nl; e++) begin
                rolling = tok[0] * mult_tab[e*MAX_NGRAM];
                for (int s = 1; s < ng; s++) begin
                    rolling = rolling ^ (tok[s] * mult_tab[e*MAX_NGRAM + s]);
                    for (int h = 0; h < nh; h++) begin
                        col = (s - 1) * nh + h;
                        base = e * COLS_PER_LAYER + col;
                        p = prime_tab[base];
                        // zero prime passes the hash straight through
                        rem = (p != 0) ? rolling % {32'b0, p} : rolling;
                        r.lay = e[0];
                        r.col = col[4:0];
                        r.row = rem[31:0] + off_tab[base];
                        cnt++;
                        r.lst = (cnt == total);
                        rows_due = {rows_due, r};
                    end
                end
            end
            // advance history, newest first
            for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = cur;
            if (hist_n < HIST_DEPTH) hist_n++;
        endfunction

        function void check_row(logic lay, logic [4:0] col, logic [31:0] row, logic lst);
            row_rec_t r;
            rows_seen++;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row: layer %0d col %0d row %h last %0d",
                         $time, lay, col, row, lst);
                errors++;
                return;
            end
            r = rows_due.pop_front();
            if (lay !== r.lay) begin
                $display("%0t: layer mismatch: expected %0d actual %0d", $time, r.lay, lay);
                errors++;
            end
            if (col !== r.col) begin
                $display("%0t: column mismatch: expected %0d actual %0d", $time, r.col, col);
                errors++;
            end
            if (row !== r.row) begin
                $display("%0t: row mismatch (col %0d): expected %h actual %h",
                         $time, r.col, r.row, row);
                errors++;
            end
            if (lst !== r.lst) begin
                $display("%0t: last mismatch: expected %0d actual %0d", $time, r.lst, lst);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    row_index_board board;
    int  burst_left;
    bit  hold_req;
    bit  hold_taken;
    int  hold_left;
    int  rx_cyc;

    ngram_hash_row_indexer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: check each accepted row, stall on a rotating pattern and once on a long hold
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_row(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[36:5], m_axis_tlast);
        rx_cyc++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 700;
            m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cyc / 97) % 3)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Random bits in every used field, so fields the request kind ignores still toggle
    function automatic logic [103:0] noise_word();
        logic [103:0] w;
        w = 104'({$urandom, $urandom, $urandom, $urandom});
        w[103:98] = '0;
        return w;
    endfunction

    function automatic logic [103:0] write_word(logic [1:0] sel, logic lay, logic [4:0] ent,
                                                logic [63:0] val);
        logic [103:0] w;
        w = noise_word();
        w[1:0] = sel;
        w[2] = lay;
        w[7:3] = ent;
        w[71:8] = val;
        return w;
    endfunction

    function automatic logic [103:0] token_word(logic [23:0] id, logic pres, logic start);
        logic [103:0] w;
        w = noise_word();
        w[95:72] = id;
        w[96] = pres;
        w[97] = start;
        return w;
    endfunction

    // Offer one request, hold it until taken, then maybe open a gap
    task automatic push(logic kind, logic [103:0] w);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= w;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_request(kind, w);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_tab(logic [1:0] sel, logic lay, logic [4:0] ent, logic [63:0] val);
        push(REQ_WRITE, write_word(sel, lay, ent, val));
    endtask

    task automatic hash_token(logic [23:0] id, logic pres, logic start);
        push(REQ_HASH, token_word(id, pres, start));
    endtask

    // Drain all rows, then let the block settle before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.rows_due.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [23:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        board.set_reg(idx, d);
    endtask

    task automatic set_config(logic [23:0] ng, logic [23:0] hd, logic [23:0] ly,
                              logic [23:0] pad);
        wait_idle();
        set_reg(CFG_NGRAM, ng);
        set_reg(CFG_HEADS, hd);
        set_reg(CFG_LAYERS, ly);
        set_reg(CFG_PAD, pad);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_prime();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(2, 1000);
            default: return $urandom;
        endcase
    endfunction

    // Random mix: mostly tokens in running sequences, some table rewrites
    task automatic random_items(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                case ($urandom_range(0, 3))
                    0: write_tab(SEL_MULT, 1'($urandom_range(0, 1)),
                                 5'($urandom_range(0, 31)), {$urandom, $urandom});
                    1: write_tab(SEL_PRIME, 1'($urandom_range(0, 1)),
                                 5'($urandom_range(0, 31)), {$urandom, pick_prime()});
                    2: write_tab(SEL_OFF, 1'($urandom_range(0, 1)),
                                 5'($urandom_range(0, 31)), {$urandom, $urandom});
                    default: write_tab(2'd3, 1'($urandom_range(0, 1)),
                                       5'($urandom_range(0, 31)), {$urandom, $urandom});
                endcase
            end else begin
                hash_token(24'($urandom), $urandom_range(0, 9) != 0,
                           $urandom_range(0, 11) == 0);
            end
        end
    endtask

    initial
    begin
        #(8 * 1_500_000);
        $display("timeout with %0d rows still expected", board.rows_due.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        board = new();
        burst_left = 1;
        hold_req = 1'b0;
        hold_taken = 1'b0;
        hold_left = 0;
        rx_cyc = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_WRITE;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every table entry before any token reads it
        for (int l = 0; l < MAX_LAYERS; l++) begin
            for (int m = 0; m < MAX_NGRAM; m++)
                write_tab(SEL_MULT, 1'(l), 5'(m), (m == 3) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                         : {$urandom, $urandom});
            for (int c = 0; c < COLS_PER_LAYER; c++) begin
                write_tab(SEL_PRIME, 1'(l), 5'(c), {$urandom, (c < 3) ? ((c == 0) ? 32'h0 :
                          (c == 1) ? 32'h1 : 32'hFFFF_FFFF) : pick_prime()});
                write_tab(SEL_OFF, 1'(l), 5'(c),
                          {$urandom, (c == 4) ? 32'hFFFF_FFFF : $urandom});
            end
        end

        // Directed: reset registers, extreme ids, absent tokens, restarts
        hash_token(24'h0, 1'b1, 1'b1);
        hash_token(24'hFF_FFFF, 1'b1, 1'b0);
        hash_token(24'h12_3456, 1'b0, 1'b0);
        hash_token(24'hFF_FFFF, 1'b1, 1'b0);
        hash_token(24'h00_0001, 1'b1, 1'b1);
        // ignored writes: bad select, entries past the table depth
        write_tab(2'd3, 1'b0, 5'd0, 64'h0);
        write_tab(SEL_MULT, 1'b1, 5'd31, 64'h0);
        write_tab(SEL_PRIME, 1'b0, 5'd24, 64'h0);
        write_tab(SEL_OFF, 1'b1, 5'd31, 64'h0);
        hash_token(24'h80_0000, 1'b1, 1'b0);

        // Above the limits: clamp to the largest size, all-ones pad
        set_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        hash_token(24'h55_5555, 1'b0, 1'b1);
        hash_token(24'hAA_AAAA, 1'b1, 1'b0);
        hash_token(24'h0, 1'b1, 1'b0);
        // Below the limits: clamp to the smallest size
        set_config(24'hFF_FFF8, 24'hFF_FFF0, 24'hFF_FFFC, 24'h00_0000);
        hash_token(24'h00_0007, 1'b1, 1'b1);
        hash_token(24'h0F_0F0F, 1'b0, 1'b0);
        set_config(24'd4, 24'd1, 24'd2, 24'h5A_5A5A);
        hash_token(24'hFF_FFFF, 1'b1, 1'b1);
        hash_token(24'h00_0000, 1'b0, 1'b0);

        // Long receiver hold while tokens keep coming
        set_config(24'd2, 24'd1, 24'd1, 24'($urandom));
        hold_req = 1'b1;
        random_items(20);

        // Random phases with small head counts to keep tokens short
        for (int ph = 0; ph < 8; ph++) begin
            set_config(24'($urandom_range(0, 7)), 24'($urandom_range(0, 3)),
                       24'($urandom_range(0, 3)), 24'($urandom));
            random_items(14);
        end
        set_config(24'd4, 24'd8, 24'd2, 24'($urandom));
        random_items(6);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d tokens and %0d table writes, %0d row indices checked",
                 board.tokens, board.writes, board.rows_seen);
        $display("register extremes, zero and unit primes, padding and restarts exercised");
        if (board.errors == 0 && board.rows_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
